// ===== rtl/attn_pkg.sv =====
package attn_pkg;

   // Field and register widths of the interface.
   localparam int VLEN_W    = 8;
   localparam int NHEADS_W  = 6;
   localparam int GRP_W     = 4;
   localparam int SCALE_W   = 17;
   localparam int HEAD_W    = 5;
   localparam int ELEM_W    = 7;
   localparam int TIME_W    = 11;
   localparam int VALUE_W   = 16;
   localparam int SCORE_W   = 32;
   localparam int ACC_W     = 48;
   localparam int CSR_IDX_W = 2;

   // Register values after reset.
   localparam logic [VLEN_W-1:0]   VLEN_RST   = 8'd64;
   localparam logic [NHEADS_W-1:0] NHEADS_RST = 6'd32;
   localparam logic [GRP_W-1:0]    GRP_RST    = 4'd1;
   localparam logic [SCALE_W-1:0]  SCALE_RST  = 17'd8192;

   // A scale of 1.0 in unsigned Q1.16; larger values are clamped to it.
   localparam logic [SCALE_W-1:0]  SCALE_ONE  = 17'h10000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VECTOR_LENGTH = 2'd0,
      CSR_N_HEADS       = 2'd1,
      CSR_GROUP_SIZE    = 2'd2,
      CSR_SCORE_SCALE   = 2'd3
   } csr_index_type;

   typedef enum logic {
      REQ_QUERY = 1'b0,
      REQ_KEY   = 1'b1
   } req_kind_type;

endpackage

// ===== rtl/attention_score_dot_scale_core.sv =====
// Query load items write the query memory directly and do not occupy the block.
// A key element occupies the block while each of the G group heads in use takes its
// turn at the single read port of the query memory.
// On the last element each score takes an accumulator read, two passes through the
// shared scale multiplier and an output step, held while the result side stalls.
// Synchronous reset clears control state and loads CSR defaults; query RAM is kept.
module attention_score_dot_scale_core #(
   parameter int HEAD_MAX  = 128,
   parameter int MAX_HEADS = 32,
   parameter int MAX_GROUP = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_type,
   input  logic [attn_pkg::HEAD_W-1:0]         req_query_head,
   input  logic [attn_pkg::HEAD_W-1:0]         req_key_head,
   input  logic [attn_pkg::ELEM_W-1:0]         req_elem_index,
   input  logic [attn_pkg::TIME_W-1:0]         req_timestep,
   input  logic signed [attn_pkg::VALUE_W-1:0] req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [attn_pkg::HEAD_W-1:0]         rsp_head_out,
   output logic [attn_pkg::TIME_W-1:0]         rsp_time_out,
   output logic signed [attn_pkg::SCORE_W-1:0] rsp_score,
   output logic                                rsp_group_last,
   input  logic                                csr_write_en,
   input  logic [attn_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [attn_pkg::SCALE_W-1:0]        csr_wdata
);

   import attn_pkg::*;

   localparam int QDEPTH  = MAX_HEADS * HEAD_MAX;
   localparam int QAW     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int GAW     = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
   localparam int BASE_W  = HEAD_W + GRP_W;
   localparam int PROD_W  = 2 * VALUE_W;
   localparam int HALF_W  = ACC_W / 2;
   localparam int MUL_A_W = HALF_W + 1;
   localparam int MUL_B_W = SCALE_W + 1;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam int LO_W    = HALF_W + SCALE_W;
   localparam int RND_W   = LO_W - HALF_W + 1;
   localparam int SUM_W   = MUL_P_W + 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_RD,
      ST_LO,
      ST_HI,
      ST_OUT
   } state_type;

   state_type state_ff, state_in;

   logic [VLEN_W-1:0]   vlen_ff, vlen_in;
   logic [NHEADS_W-1:0] nheads_ff, nheads_in;
   logic [GRP_W-1:0]    grp_ff, grp_in;
   logic [SCALE_W-1:0]  scale_ff, scale_in;

   logic [VLEN_W-1:0]   len_eff;
   logic [GRP_W-1:0]    grp_eff;
   logic [NHEADS_W-1:0] heads_eff;
   logic [SCALE_W-1:0]  scale_eff;

   logic [ELEM_W-1:0]         elem_ff, elem_in;
   logic [TIME_W-1:0]         time_ff, time_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic [BASE_W-1:0]         base_ff, base_in;
   logic [GRP_W-1:0]          cnt_ff, cnt_in;
   logic                      last_ff, last_in;
   logic [GRP_W-1:0]          j_ff, j_in;
   logic [MAX_GROUP-1:0]      vld_ff, vld_in;

   logic                      s1_vld_ff, s1_vld_in;
   logic [GAW-1:0]            s1_j_ff, s1_j_in;
   logic                      s2_vld_ff, s2_vld_in;
   logic [GAW-1:0]            s2_j_ff, s2_j_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   accv_ff, accv_in;

   logic [HALF_W-1:0]         dot_hi_ff, dot_hi_in;
   logic [LO_W-1:0]           lo_prod_ff, lo_prod_in;
   logic signed [MUL_P_W-1:0] hi_prod_ff, hi_prod_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [HEAD_W-1:0]         rsp_head_ff, rsp_head_in;
   logic [TIME_W-1:0]         rsp_time_ff, rsp_time_in;
   logic signed [SCORE_W-1:0] rsp_score_ff, rsp_score_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic                      req_acc;
   logic                      key_in_range;
   logic                      is_last_calc;
   logic [BASE_W-1:0]         base_calc;
   logic [BASE_W-1:0]         heads_w;
   logic [BASE_W-1:0]         diff_calc;
   logic [GRP_W-1:0]          cnt_calc;
   logic [BASE_W-1:0]         h_cur;

   logic                      q_wr_en;
   logic [QAW-1:0]            q_wr_addr;
   logic [QAW-1:0]            q_rd_addr;
   logic [VALUE_W-1:0]        q_rd_data;
   logic [GAW-1:0]            acc_rd_addr;
   logic [ACC_W-1:0]          acc_rd_data;
   logic [ACC_W-1:0]          acc_wr_data;

   logic [ACC_W-1:0]          dot_cur;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] mul_p;
   logic [LO_W:0]             lo_rnd;
   logic [RND_W-1:0]          rnd;
   logic signed [SUM_W-1:0]   sum;
   logic [SUM_W-SCORE_W:0]    sum_top;
   logic signed [SCORE_W-1:0] score_sat;
   logic                      out_free;

   // Register clamping.
   always_comb begin
      if (vlen_ff == '0) begin
         len_eff = VLEN_W'(1);
      end else if (int'(vlen_ff) > HEAD_MAX) begin
         len_eff = VLEN_W'(HEAD_MAX);
      end else begin
         len_eff = vlen_ff;
      end
      if (grp_ff == '0) begin
         grp_eff = GRP_W'(1);
      end else if (int'(grp_ff) > MAX_GROUP) begin
         grp_eff = GRP_W'(MAX_GROUP);
      end else begin
         grp_eff = grp_ff;
      end
      if (int'(nheads_ff) > MAX_HEADS) begin
         heads_eff = NHEADS_W'(MAX_HEADS);
      end else begin
         heads_eff = nheads_ff;
      end
      scale_eff = (scale_ff > SCALE_ONE) ? SCALE_ONE : scale_ff;
   end

   always_comb begin
      vlen_in   = vlen_ff;
      nheads_in = nheads_ff;
      grp_in    = grp_ff;
      scale_in  = scale_ff;
      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_VECTOR_LENGTH: vlen_in   = csr_wdata[VLEN_W-1:0];
            CSR_N_HEADS:       nheads_in = csr_wdata[NHEADS_W-1:0];
            CSR_GROUP_SIZE:    grp_in    = csr_wdata[GRP_W-1:0];
            CSR_SCORE_SCALE:   scale_in  = csr_wdata;
            default:           vlen_in   = vlen_ff;
         endcase
      end
   end

   assign req_acc      = req_valid && !req_stall;
   assign key_in_range = VLEN_W'(req_elem_index) < len_eff;
   assign is_last_calc = VLEN_W'(req_elem_index) == (len_eff - 1'b1);

   // The group of a key head is heads base .. base+grp-1; only those below the
   // head count take part, and they always form a run starting at the base.
   assign base_calc = BASE_W'(req_key_head) * BASE_W'(grp_eff);
   assign heads_w   = BASE_W'(heads_eff);
   assign diff_calc = heads_w - base_calc;

   always_comb begin
      if (base_calc >= heads_w) begin
         cnt_calc = '0;
      end else if (diff_calc < BASE_W'(grp_eff)) begin
         cnt_calc = GRP_W'(diff_calc);
      end else begin
         cnt_calc = grp_eff;
      end
   end

   assign q_wr_en   = req_acc && (req_type == REQ_QUERY)
                      && (int'(req_query_head) < MAX_HEADS)
                      && (int'(req_elem_index) < HEAD_MAX);
   assign q_wr_addr = QAW'(req_query_head) * QAW'(HEAD_MAX) + QAW'(req_elem_index);

   assign h_cur       = base_ff + BASE_W'(j_ff);
   assign q_rd_addr   = QAW'(h_cur) * QAW'(HEAD_MAX) + QAW'(elem_ff);
   assign acc_rd_addr = GAW'(j_ff);
   assign acc_wr_data = accv_ff + ACC_W'(prod_ff);

   attn_ram #(
      .WIDTH(VALUE_W),
      .DEPTH(QDEPTH)
   ) u_query_ram (
      .clock  (clock),
      .wr_en  (q_wr_en),
      .wr_addr(q_wr_addr),
      .wr_data(req_value),
      .rd_addr(q_rd_addr),
      .rd_data(q_rd_data)
   );

   attn_ram #(
      .WIDTH(ACC_W),
      .DEPTH(MAX_GROUP)
   ) u_acc_ram (
      .clock  (clock),
      .wr_en  (s2_vld_ff),
      .wr_addr(s2_j_ff),
      .wr_data(acc_wr_data),
      .rd_addr(acc_rd_addr),
      .rd_data(acc_rd_data)
   );

   // Shared scale multiplier: the low half of the dot product goes through as an
   // unsigned operand in ST_LO, then the high half as a signed one in ST_HI.
   assign dot_cur = vld_ff[GAW'(j_ff)] ? acc_rd_data : '0;
   assign mul_b   = {1'b0, scale_eff};

   always_comb begin
      if (state_ff == ST_LO) begin
         mul_a = {1'b0, dot_cur[HALF_W-1:0]};
      end else if (state_ff == ST_HI) begin
         mul_a = {dot_hi_ff[HALF_W-1], dot_hi_ff};
      end else begin
         mul_a = '0;
      end
   end

   assign mul_p   = mul_a * mul_b;

   // floor((hi*2^24 + lo) * scale + 2^23) / 2^24) = hi*scale + round(lo*scale / 2^24).
   assign lo_rnd  = {1'b0, lo_prod_ff} + (LO_W+1)'(1 << (HALF_W - 1));
   assign rnd     = lo_rnd[LO_W:HALF_W];
   assign sum     = SUM_W'(hi_prod_ff) + SUM_W'(rnd);
   assign sum_top = sum[SUM_W-1:SCORE_W-1];

   always_comb begin
      if ((&sum_top) || !(|sum_top)) begin
         score_sat = sum[SCORE_W-1:0];
      end else if (sum[SUM_W-1]) begin
         score_sat = {1'b1, {(SCORE_W-1){1'b0}}};
      end else begin
         score_sat = {1'b0, {(SCORE_W-1){1'b1}}};
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      elem_in      = elem_ff;
      time_in      = time_ff;
      value_in     = value_ff;
      base_in      = base_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      j_in         = j_ff;
      vld_in       = vld_ff;
      s1_vld_in    = 1'b0;
      s1_j_in      = s1_j_ff;
      s2_vld_in    = s1_vld_ff;
      s2_j_in      = s1_j_ff;
      prod_in      = $signed(q_rd_data) * value_ff;
      accv_in      = vld_ff[s1_j_ff] ? $signed(acc_rd_data) : '0;
      dot_hi_in    = dot_hi_ff;
      lo_prod_in   = lo_prod_ff;
      hi_prod_in   = hi_prod_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_head_in  = rsp_head_ff;
      rsp_time_in  = rsp_time_ff;
      rsp_score_in = rsp_score_ff;
      rsp_last_in  = rsp_last_ff;

      if (s2_vld_ff) begin
         vld_in[s2_j_ff] = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_type == REQ_KEY) && key_in_range) begin
               elem_in  = req_elem_index;
               time_in  = req_timestep;
               value_in = req_value;
               base_in  = base_calc;
               cnt_in   = cnt_calc;
               last_in  = is_last_calc;
               j_in     = '0;
               if (req_elem_index == '0) begin
                  vld_in = '0;
               end
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            if (j_ff < cnt_ff) begin
               s1_vld_in = 1'b1;
               s1_j_in   = GAW'(j_ff);
               j_in      = j_ff + 1'b1;
            end else if (!s1_vld_ff && !s2_vld_ff) begin
               j_in = '0;
               if (last_ff && (cnt_ff != '0)) begin
                  state_in = ST_RD;
               end else begin
                  if (last_ff) begin
                     vld_in = '0;
                  end
                  state_in = ST_IDLE;
               end
            end
         end
         ST_RD: begin
            state_in = ST_LO;
         end
         ST_LO: begin
            lo_prod_in = LO_W'(mul_p);
            dot_hi_in  = dot_cur[ACC_W-1:HALF_W];
            state_in   = ST_HI;
         end
         ST_HI: begin
            hi_prod_in = mul_p;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_head_in  = h_cur[HEAD_W-1:0];
               rsp_time_in  = time_ff;
               rsp_score_in = score_sat;
               rsp_last_in  = (j_ff == (cnt_ff - 1'b1));
               if (j_ff == (cnt_ff - 1'b1)) begin
                  vld_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  j_in     = j_ff + 1'b1;
                  state_in = ST_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vlen_ff      <= VLEN_RST;
         nheads_ff    <= NHEADS_RST;
         grp_ff       <= GRP_RST;
         scale_ff     <= SCALE_RST;
         j_ff         <= '0;
         vld_ff       <= '0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vlen_ff      <= vlen_in;
         nheads_ff    <= nheads_in;
         grp_ff       <= grp_in;
         scale_ff     <= scale_in;
         j_ff         <= j_in;
         vld_ff       <= vld_in;
         s1_vld_ff    <= s1_vld_in;
         s2_vld_ff    <= s2_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         elem_ff      <= elem_in;
         time_ff      <= time_in;
         value_ff     <= value_in;
         base_ff      <= base_in;
         cnt_ff       <= cnt_in;
         last_ff      <= last_in;
         s1_j_ff      <= s1_j_in;
         s2_j_ff      <= s2_j_in;
         prod_ff      <= prod_in;
         accv_ff      <= accv_in;
         dot_hi_ff    <= dot_hi_in;
         lo_prod_ff   <= lo_prod_in;
         hi_prod_ff   <= hi_prod_in;
         rsp_head_ff  <= rsp_head_in;
         rsp_time_ff  <= rsp_time_in;
         rsp_score_ff <= rsp_score_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_head_out   = rsp_head_ff;
   assign rsp_time_out   = rsp_time_ff;
   assign rsp_score      = rsp_score_ff;
   assign rsp_group_last = rsp_last_ff;

endmodule

// ===== rtl/attn_ram.sv =====
module attn_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/attn_checker.sv =====
module attn_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                req_type,
   input logic [attn_pkg::HEAD_W-1:0]         req_query_head,
   input logic [attn_pkg::HEAD_W-1:0]         req_key_head,
   input logic [attn_pkg::ELEM_W-1:0]         req_elem_index,
   input logic [attn_pkg::TIME_W-1:0]         req_timestep,
   input logic signed [attn_pkg::VALUE_W-1:0] req_value,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [attn_pkg::HEAD_W-1:0]         rsp_head_out,
   input logic [attn_pkg::TIME_W-1:0]         rsp_time_out,
   input logic signed [attn_pkg::SCORE_W-1:0] rsp_score,
   input logic                                rsp_group_last,
   input logic                                csr_write_en,
   input logic [attn_pkg::CSR_IDX_W-1:0]      csr_index,
   input logic [attn_pkg::SCALE_W-1:0]        csr_wdata
);

   import attn_pkg::*;

   // A stalled result item keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_head_out)
         && $stable(rsp_time_out) && $stable(rsp_score) && $stable(rsp_group_last))
      else $error("result item changed while stalled");

   // Reset leaves no result pending and the input side open.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

   // Once a score that is not the last of its group leaves, the rest of the
   // group is either already shown or still being worked on.
   a_group_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_group_last |=> rsp_valid || req_stall)
      else $error("group ended without its last score");

   // A query load never produces a result and never occupies the block.
   a_query_quiet: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_type == REQ_QUERY) && !rsp_valid
         |=> !rsp_valid && !req_stall)
      else $error("query load caused a result or a busy cycle");

endmodule

bind attention_score_dot_scale_core attn_checker u_attn_checker (.*);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import attn_pkg::*;

   localparam int HEAD_MAX     = 128;
   localparam int MAX_HEADS    = 32;
   localparam int MAX_GROUP    = 8;
   localparam int DRAIN_CYCLES = 80;
   localparam int CYCLE_LIMIT  = 500000;

   typedef struct {
      req_kind_type               kind;
      logic [HEAD_W-1:0]          query_head;
      logic [HEAD_W-1:0]          key_head;
      logic [ELEM_W-1:0]          elem;
      logic [TIME_W-1:0]          tstep;
      logic signed [VALUE_W-1:0]  value;
   } attn_item_type;

   typedef struct {
      logic [HEAD_W-1:0]          head;
      logic [TIME_W-1:0]          tstep;
      logic signed [SCORE_W-1:0]  score;
      logic                       last;
   } score_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic                         req_type = REQ_QUERY;
   logic [HEAD_W-1:0]            req_query_head = '0;
   logic [HEAD_W-1:0]            req_key_head = '0;
   logic [ELEM_W-1:0]            req_elem_index = '0;
   logic [TIME_W-1:0]            req_timestep = '0;
   logic signed [VALUE_W-1:0]    req_value = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [HEAD_W-1:0]            rsp_head_out;
   logic [TIME_W-1:0]            rsp_time_out;
   logic signed [SCORE_W-1:0]    rsp_score;
   logic                         rsp_group_last;
   logic                         csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]         csr_index = '0;
   logic [SCALE_W-1:0]           csr_wdata = '0;

   // Our own copy of the configuration registers.
   logic [VLEN_W-1:0]            cfg_vlen   = VLEN_RST;
   logic [NHEADS_W-1:0]          cfg_nheads = NHEADS_RST;
   logic [GRP_W-1:0]             cfg_grp    = GRP_RST;
   logic [SCALE_W-1:0]           cfg_scale  = SCALE_RST;

   logic signed [VALUE_W-1:0]    query_mem [MAX_HEADS*HEAD_MAX];
   logic signed [ACC_W-1:0]      dot_acc [MAX_GROUP];
   bit                           query_loaded [MAX_HEADS*HEAD_MAX];

   attn_item_type                pending [$];
   attn_item_type                cur_item;
   score_type                    score_q [$];
   score_type                    want;

   int                           keys_queued = 0;
   int                           fail_count = 0;
   int                           burst_left = 0;
   int                           gap_left = 0;
   int                           stall_mode = 0;
   int                           stall_left = 0;
   int                           cycle_count = 0;

   attention_score_dot_scale_core DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_query_head (req_query_head),
      .req_key_head   (req_key_head),
      .req_elem_index (req_elem_index),
      .req_timestep   (req_timestep),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_head_out   (rsp_head_out),
      .rsp_time_out   (rsp_time_out),
      .rsp_score      (rsp_score),
      .rsp_group_last (rsp_group_last),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Register values as the block interprets them, out-of-range ones clamped.
   function automatic int eff_len();
      if (cfg_vlen == 0) return 1;
      return (cfg_vlen > HEAD_MAX) ? HEAD_MAX : int'(cfg_vlen);
   endfunction

   function automatic int eff_grp();
      if (cfg_grp == 0) return 1;
      return (cfg_grp > MAX_GROUP) ? MAX_GROUP : int'(cfg_grp);
   endfunction

   function automatic int eff_heads();
      return (cfg_nheads > MAX_HEADS) ? MAX_HEADS : int'(cfg_nheads);
   endfunction

   function automatic logic [SCALE_W-1:0] eff_scale();
      return (cfg_scale > SCALE_ONE) ? SCALE_ONE : cfg_scale;
   endfunction

   // Q24.24 dot times Q1.16 scale, rounded half up to Q16.16 and saturated.
   function automatic logic signed [SCORE_W-1:0] scale_score(
      input logic signed [ACC_W-1:0] dot, input logic [SCALE_W-1:0] scale);
      longint p;
      p = (longint'(dot) * longint'(scale) + (longint'(1) << 23)) >>> 24;
      if (p > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (p < -64'sd2147483648) return 32'sh8000_0000;
      return p[SCORE_W-1:0];
   endfunction

   task automatic apply_item(input attn_item_type it);
      int len;
      int grp;
      int heads;
      int base;
      int h;
      int n_use;
      int k;
      score_type s;
      len = eff_len();
      grp = eff_grp();
      heads = eff_heads();
      if (it.kind == REQ_QUERY) begin
         query_mem[it.query_head * HEAD_MAX + it.elem] = it.value;
         return;
      end
      if (it.elem >= len) return;
      if (it.elem == 0) begin
         foreach (dot_acc[j]) dot_acc[j] = '0;
      end
      base = it.key_head * grp;
      n_use = 0;
      for (int j = 0; j < grp; j++) begin
         h = base + j;
         if (h < heads) begin
            dot_acc[j] += longint'(query_mem[h * HEAD_MAX + it.elem]) * longint'(it.value);
            n_use++;
         end
      end
      if (it.elem != len - 1) return;
      k = 0;
      for (int j = 0; j < grp; j++) begin
         h = base + j;
         if (h < heads) begin
            s.head = HEAD_W'(h);
            s.tstep = it.tstep;
            s.score = scale_score(dot_acc[j], eff_scale());
            s.last = (k == n_use - 1);
            score_q.push_back(s);
            k++;
         end
      end
      foreach (dot_acc[j]) dot_acc[j] = '0;
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return '0;
         3: return VALUE_W'(int'($urandom_range(0, 15)) - 8);
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   function automatic int pick_key_head();
      int heads;
      heads = eff_heads();
      if (heads == 0 || $urandom_range(0, 5) == 0) return $urandom_range(0, 31);
      return $urandom_range(0, (heads - 1) / eff_grp());
   endfunction

   task automatic add_query(input int h, input int e, input logic signed [VALUE_W-1:0] v);
      attn_item_type it;
      it.kind = REQ_QUERY;
      it.query_head = HEAD_W'(h);
      it.key_head = HEAD_W'($urandom);
      it.elem = ELEM_W'(e);
      it.tstep = TIME_W'($urandom);
      it.value = v;
      pending.push_back(it);
      query_loaded[h * HEAD_MAX + e] = 1'b1;
   endtask

   // Any query entry this key element will read is loaded first if it never was.
   task automatic add_key(input int kh, input int e, input int t,
                          input logic signed [VALUE_W-1:0] v);
      attn_item_type it;
      int h;
      if (e < eff_len()) begin
         for (int j = 0; j < eff_grp(); j++) begin
            h = kh * eff_grp() + j;
            if (h < eff_heads() && !query_loaded[h * HEAD_MAX + e])
               add_query(h, e, pick_value());
         end
      end
      it.kind = REQ_KEY;
      it.query_head = HEAD_W'($urandom);
      it.key_head = HEAD_W'(kh);
      it.elem = ELEM_W'(e);
      it.tstep = TIME_W'(t);
      it.value = v;
      pending.push_back(it);
      keys_queued++;
   endtask

   task automatic add_vector(input int kh, input int t);
      for (int e = 0; e < eff_len(); e++) add_key(kh, e, t, pick_value());
   endtask

   task automatic random_keys(input int target);
      int stop_at;
      int len;
      int kh;
      int kh2;
      int cut;
      int skip;
      int t;
      stop_at = keys_queued + target;
      len = eff_len();
      while (keys_queued < stop_at) begin
         t = $urandom_range(0, 2047);
         kh = pick_key_head();
         case ($urandom_range(0, 19))
            0, 1: add_query($urandom_range(0, 31), $urandom_range(0, 127), pick_value());
            2: begin
               if (len < HEAD_MAX) add_key(kh, $urandom_range(len, 127), t, pick_value());
            end
            3: begin
               // Abandoned vector: the next element 0 has to start over.
               cut = $urandom_range(0, len - 1);
               for (int e = 0; e <= cut; e++) add_key(kh, e, t, pick_value());
            end
            4, 5: begin
               // Key head and timestep change partway, and maybe one element is missing.
               kh2 = pick_key_head();
               cut = $urandom_range(0, len - 1);
               skip = $urandom_range(0, 2 * len);
               for (int e = 0; e < len; e++) begin
                  if (e != skip)
                     add_key(e > cut ? kh2 : kh, e, e > cut ? $urandom_range(0, 2047) : t,
                             pick_value());
               end
            end
            default: add_vector(kh, t);
         endcase
      end
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [SCALE_W-1:0] data);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_VECTOR_LENGTH: cfg_vlen = data[VLEN_W-1:0];
         CSR_N_HEADS:       cfg_nheads = data[NHEADS_W-1:0];
         CSR_GROUP_SIZE:    cfg_grp = data[GRP_W-1:0];
         CSR_SCORE_SCALE:   cfg_scale = data;
         default: ;
      endcase
   endtask

   task automatic program_regs(input int vlen, input int nheads, input int grp,
                               input int scale);
      write_reg(CSR_VECTOR_LENGTH, SCALE_W'(vlen));
      write_reg(CSR_N_HEADS, SCALE_W'(nheads));
      write_reg(CSR_GROUP_SIZE, SCALE_W'(grp));
      write_reg(CSR_SCORE_SCALE, SCALE_W'(scale));
   endtask

   // Key elements that end no vector leave nothing expected while the block may
   // still be busy, so a fixed drain follows once the expectations are met.
   task automatic settle();
      while (pending.size() != 0 || req_valid || score_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) apply_item(cur_item);
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending.size() != 0) begin
               cur_item = pending.pop_front();
               req_valid <= 1'b1;
               req_type <= cur_item.kind;
               req_query_head <= cur_item.query_head;
               req_key_head <= cur_item.key_head;
               req_elem_index <= cur_item.elem;
               req_timestep <= cur_item.tstep;
               req_value <= cur_item.value;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (score_q.size() == 0) begin
               $error("unexpected score for head %0d time %0d", rsp_head_out, rsp_time_out);
               fail_count++;
            end else begin
               want = score_q.pop_front();
               if (rsp_head_out !== want.head) begin
                  $error("head_out: expected %0d, got %0d", want.head, rsp_head_out);
                  fail_count++;
               end
               if (rsp_time_out !== want.tstep) begin
                  $error("time_out: expected %0d, got %0d", want.tstep, rsp_time_out);
                  fail_count++;
               end
               if (rsp_score !== want.score) begin
                  $error("score: expected %0d, got %0d", want.score, rsp_score);
                  fail_count++;
               end
               if (rsp_group_last !== want.last) begin
                  $error("group_last: expected %0d, got %0d", want.last, rsp_group_last);
                  fail_count++;
               end
            end
         end
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 120);
         end else begin
            stall_left--;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 2) == 0);
            2: rsp_stall <= ((stall_left % 8) < 5);
            default: rsp_stall <= ($urandom_range(0, 9) != 0);
         endcase
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // One vector under the register values left by reset; the middle elements
      // are left out, so the sum covers the first and the last few.
      for (int e = 0; e < eff_len(); e++) begin
         if (e < 4 || e >= eff_len() - 4) add_key(7, e, 100, pick_value());
      end
      settle();

      // Directed: extremes, a group at the top heads, a fully skipped group,
      // an element past the vector end, a restart and a key head change.
      program_regs(2, 32, 2, 65536);
      add_query(0, 0, 16'sh8000);
      add_query(0, 1, 16'sh7FFF);
      add_query(1, 0, 16'sh7FFF);
      add_query(1, 1, 16'sh8000);
      add_key(0, 0, 2047, 16'sh8000);
      add_key(0, 1, 2047, 16'sh7FFF);
      add_key(15, 0, 0, 16'sh7FFF);
      add_key(15, 1, 0, 16'sh0000);
      add_key(31, 0, 5, 16'sh0001);
      add_key(31, 1, 5, 16'sh0001);
      add_key(0, 127, 3, 16'sh7FFF);
      add_key(1, 0, 9, 16'sh0064);
      add_key(1, 0, 9, -16'sh0005);
      add_key(1, 1, 10, 16'sh0007);
      add_key(2, 0, 11, 16'sh1000);
      add_key(3, 1, 12, -16'sh1000);
      settle();

      // The length register is all ones and reads as the longest vector; its first
      // and last elements carry the largest products.
      program_regs(255, 32, 1, 65536);
      for (int e = 0; e < 4; e++) begin
         add_query(31, e, 16'sh8000);
         add_key(31, e, 1365, 16'sh8000);
      end
      for (int e = HEAD_MAX - 4; e < HEAD_MAX; e++) begin
         add_query(31, e, 16'sh8000);
         add_key(31, e, 1365, 16'sh8000);
      end
      settle();

      // Zero length and group, too many heads, scale above one.
      program_regs(0, 63, 0, 131071);
      random_keys(12);
      settle();

      // No head in use: nothing is ever scored.
      program_regs(3, 0, 8, 0);
      random_keys(8);
      settle();

      // Oversized group with part of the top group beyond the heads in use.
      program_regs(5, 20, 15, $urandom_range(0, 65536));
      random_keys(12);
      settle();

      program_regs(4, 32, 8, 1);
      random_keys(10);
      settle();

      for (int p = 0; p < 4; p++) begin
         program_regs($urandom_range(1, 8), $urandom_range(1, 32), $urandom_range(1, 8),
                      $urandom_range(0, 65536));
         random_keys(10);
         settle();
      end

      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
